// ----- sv/awa_pkg.sv -----
// ----------------------------------------------------------------------------
// awa_pkg
// Shared types, constants and helpers of the inverse affine warp address core.
// ----------------------------------------------------------------------------
package awa_pkg;

  localparam int COORD_BITS = 12;
  localparam int COEF_BITS  = 32;
  localparam int DIM_BITS   = 13;
  // signed coefficient times zero-extended coordinate
  localparam int PROD_BITS  = COEF_BITS + COORD_BITS + 1;
  // two products plus an offset, with headroom
  localparam int SUM_BITS   = PROD_BITS + 2;
  localparam logic [DIM_BITS-1:0] DIM_MAX = DIM_BITS'(1 << COORD_BITS);

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_COEF_XX       = 3'd0,
    REG_COEF_XY       = 3'd1,
    REG_COEF_XT       = 3'd2,
    REG_COEF_YX       = 3'd3,
    REG_COEF_YY       = 3'd4,
    REG_COEF_YT       = 3'd5,
    REG_SOURCE_WIDTH  = 3'd6,
    REG_SOURCE_HEIGHT = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] dest_x;
    logic [COORD_BITS-1:0] dest_y;
  } dest_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] src_col;
    logic [COORD_BITS-1:0] src_row;
    logic                  inside_res;
  } src_item_t;

  // register file contents seen by the datapath
  typedef struct packed {
    logic signed [COEF_BITS-1:0] coef_xx;
    logic signed [COEF_BITS-1:0] coef_xy;
    logic signed [COEF_BITS-1:0] coef_xt;
    logic signed [COEF_BITS-1:0] coef_yx;
    logic signed [COEF_BITS-1:0] coef_yy;
    logic signed [COEF_BITS-1:0] coef_yt;
    logic [DIM_BITS-1:0]         source_width;
    logic [DIM_BITS-1:0]         source_height;
  } cfg_t;

  // partial products handed from front to back
  typedef struct packed {
    logic signed [PROD_BITS-1:0] p_xx;
    logic signed [PROD_BITS-1:0] p_xy;
    logic signed [PROD_BITS-1:0] p_yx;
    logic signed [PROD_BITS-1:0] p_yy;
  } prod_t;

  // oversize dimensions act as the largest addressable one
  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] d);
    return (d > DIM_MAX) ? DIM_MAX : d;
  endfunction

endpackage

// ----- sv/awa_front.sv -----
// ----------------------------------------------------------------------------
// awa_front
// Accepts destination pixels and forms the four coefficient products.
// ----------------------------------------------------------------------------
module awa_front (
  input  logic                clk,
  input  logic                rst,
  input  awa_pkg::cfg_t       cfg,
  input  logic                dest_valid,
  output logic                dest_stall,
  input  awa_pkg::dest_item_t dest,
  output logic                push,
  output awa_pkg::prod_t      push_data,
  input  logic                q_full
);

  logic                                   valid;
  logic signed [awa_pkg::PROD_BITS-1:0]   p_xx;
  logic signed [awa_pkg::PROD_BITS-1:0]   p_xy;
  logic signed [awa_pkg::PROD_BITS-1:0]   p_yx;
  logic signed [awa_pkg::PROD_BITS-1:0]   p_yy;
  logic signed [awa_pkg::COORD_BITS:0]    dx;
  logic signed [awa_pkg::COORD_BITS:0]    dy;
  logic                                   take;

  // handshake: stage frees when the queue takes its item
  assign push       = valid & ~q_full;
  assign dest_stall = valid & q_full;
  assign take       = dest_valid & ~dest_stall;

  // coordinates as non-negative signed operands
  assign dx = $signed({1'b0, dest.dest_x});
  assign dy = $signed({1'b0, dest.dest_y});

  // product register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (push) begin
      valid <= 1'b0;
    end
    if (take) begin
      p_xx <= cfg.coef_xx * dx;
      p_xy <= cfg.coef_xy * dy;
      p_yx <= cfg.coef_yx * dx;
      p_yy <= cfg.coef_yy * dy;
    end
  end

  assign push_data.p_xx = p_xx;
  assign push_data.p_xy = p_xy;
  assign push_data.p_yx = p_yx;
  assign push_data.p_yy = p_yy;

endmodule

// ----- sv/awa_queue.sv -----
// ----------------------------------------------------------------------------
// awa_queue
// Two-entry queue of partial products between the front and the back.
// ----------------------------------------------------------------------------
module awa_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  awa_pkg::prod_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output awa_pkg::prod_t pop_data
);

  awa_pkg::prod_t entry [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full     = (count == 2'd2);
  assign q_valid  = (count != 2'd0);
  assign pop_data = entry[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // no write into a full queue, no read from an empty one
  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("awa_queue: push while full");
  assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("awa_queue: pop while empty");
  assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("awa_queue: fill level out of range");

endmodule

// ----- sv/awa_back.sv -----
// ----------------------------------------------------------------------------
// awa_back
// Sums the products, tests the bounds and holds the result for the consumer.
// ----------------------------------------------------------------------------
module awa_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  awa_pkg::cfg_t      cfg,
  input  logic               q_valid,
  input  awa_pkg::prod_t     pop_data,
  output logic               pop,
  output logic               src_valid,
  input  logic               src_stall,
  output awa_pkg::src_item_t src
);

  localparam int SW = awa_pkg::SUM_BITS;
  localparam int CB = awa_pkg::COORD_BITS;

  logic signed [SW-1:0]             sx;
  logic signed [SW-1:0]             sy;
  logic signed [SW-1:0]             lim_x;
  logic signed [SW-1:0]             lim_y;
  logic [awa_pkg::DIM_BITS-1:0]     dim_x;
  logic [awa_pkg::DIM_BITS-1:0]     dim_y;
  logic                             in_x;
  logic                             in_y;
  logic                             in_src;
  awa_pkg::src_item_t               res;

  // affine sums, exact
  assign sx = SW'(pop_data.p_xx) + SW'(pop_data.p_xy) + SW'(cfg.coef_xt);
  assign sy = SW'(pop_data.p_yx) + SW'(pop_data.p_yy) + SW'(cfg.coef_yt);

  // last valid column and row in fixed point
  assign dim_x = awa_pkg::clamp_dim(cfg.source_width);
  assign dim_y = awa_pkg::clamp_dim(cfg.source_height);
  assign lim_x = $signed(SW'(dim_x - awa_pkg::DIM_BITS'(1)) << FRAC_BITS);
  assign lim_y = $signed(SW'(dim_y - awa_pkg::DIM_BITS'(1)) << FRAC_BITS);

  // bounds test
  assign in_x   = (dim_x != '0) && !sx[SW-1] && (sx <= lim_x);
  assign in_y   = (dim_y != '0) && !sy[SW-1] && (sy <= lim_y);
  assign in_src = in_x & in_y;

  assign res.src_col    = in_src ? sx[FRAC_BITS +: CB] : '0;
  assign res.src_row    = in_src ? sy[FRAC_BITS +: CB] : '0;
  assign res.inside_res = in_src;

  // output register frees when the consumer takes its item
  assign pop = q_valid & (~src_valid | ~src_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      src_valid <= 1'b0;
    end else if (pop) begin
      src_valid <= 1'b1;
    end else if (!src_stall) begin
      src_valid <= 1'b0;
    end
    if (pop) begin
      src <= res;
    end
  end

  // an outside point always reads as black at the origin
  assert property (@(posedge clk) disable iff (rst)
      src_valid && !src.inside_res |-> src.src_col == '0 && src.src_row == '0)
    else $error("awa_back: outside result with nonzero coordinates");

endmodule

// ----- sv/affine_inverse_warp_address_core.sv -----
// ----------------------------------------------------------------------------
// affine_inverse_warp_address_core
// Maps each destination pixel back through an inverse affine matrix and
// reports the source pixel whose cell holds the mapped point, or black when
// that point falls outside.
// The core takes one destination pixel per clock and returns one result per
// clock while neither side stalls. Each item passes a register after the four
// coefficient multipliers, a two-entry queue, and the output register after
// the sum and bounds test. The queue lets input and output stall independently.
// The matrix and source size registers may be written
// only while no item is in flight.
module affine_inverse_warp_address_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               dest_valid,
  output logic               dest_stall,
  input  awa_pkg::dest_item_t dest,
  output logic               src_valid,
  input  logic               src_stall,
  output awa_pkg::src_item_t src,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [31:0]        wr_data
);

  awa_pkg::cfg_t  cfg;
  awa_pkg::prod_t push_data;
  awa_pkg::prod_t pop_data;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_xx       <= awa_pkg::COEF_BITS'(1 << FRAC_BITS);
      cfg.coef_xy       <= '0;
      cfg.coef_xt       <= '0;
      cfg.coef_yx       <= '0;
      cfg.coef_yy       <= awa_pkg::COEF_BITS'(1 << FRAC_BITS);
      cfg.coef_yt       <= '0;
      cfg.source_width  <= awa_pkg::DIM_BITS'(640);
      cfg.source_height <= awa_pkg::DIM_BITS'(480);
    end else if (wr_en) begin
      case (awa_pkg::reg_idx_t'(wr_index))
        awa_pkg::REG_COEF_XX:       cfg.coef_xx       <= $signed(wr_data);
        awa_pkg::REG_COEF_XY:       cfg.coef_xy       <= $signed(wr_data);
        awa_pkg::REG_COEF_XT:       cfg.coef_xt       <= $signed(wr_data);
        awa_pkg::REG_COEF_YX:       cfg.coef_yx       <= $signed(wr_data);
        awa_pkg::REG_COEF_YY:       cfg.coef_yy       <= $signed(wr_data);
        awa_pkg::REG_COEF_YT:       cfg.coef_yt       <= $signed(wr_data);
        awa_pkg::REG_SOURCE_WIDTH:  cfg.source_width  <= wr_data[awa_pkg::DIM_BITS-1:0];
        awa_pkg::REG_SOURCE_HEIGHT: cfg.source_height <= wr_data[awa_pkg::DIM_BITS-1:0];
        default:                    cfg               <= cfg;
      endcase
    end
  end

  // multiplier front end
  awa_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .dest_valid (dest_valid),
    .dest_stall (dest_stall),
    .dest       (dest),
    .push       (push),
    .push_data  (push_data),
    .q_full     (q_full)
  );

  // product queue
  awa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .pop_data  (pop_data)
  );

  // sum, bounds test and output register
  awa_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .pop_data  (pop_data),
    .pop       (pop),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src       (src)
  );

endmodule

// ----- verif/affine_inverse_warp_address_checker.sv -----
// ----------------------------------------------------------------------------
// affine_inverse_warp_address_checker
// Watches the pixel channels and register writes of the warp address core,
// predicts the source pixel of each accepted destination pixel and compares
// each returned item with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module affine_inverse_warp_address_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                dest_valid,
  input  logic                dest_stall,
  input  awa_pkg::dest_item_t dest,
  input  logic                src_valid,
  input  logic                src_stall,
  input  awa_pkg::src_item_t  src,
  input  logic                wr_en,
  input  logic [2:0]          wr_index,
  input  logic [31:0]         wr_data,
  output int                  mismatches,
  output int                  outstanding
);

  localparam int FRAC = 16;

  // shadow copy of the matrix and source size
  int                           mat_xx, mat_xy, mat_xt, mat_yx, mat_yy, mat_yt;
  logic [awa_pkg::DIM_BITS-1:0] img_width, img_height;

  // predicted source pixels, oldest first
  awa_pkg::src_item_t predicted_src[$];

  // exact fixed-point test of one axis against [0, dim-1]
  function automatic logic axis_hit(input longint pos,
                                    input logic [awa_pkg::DIM_BITS-1:0] dim,
                                    output logic [awa_pkg::COORD_BITS-1:0] pix);
    logic [awa_pkg::DIM_BITS-1:0] span;
    longint                       limit;
    span = (dim > awa_pkg::DIM_MAX) ? awa_pkg::DIM_MAX : dim;
    pix  = '0;
    if (span == '0 || pos < 0) return 1'b0;
    limit = longint'(span - 1'b1) <<< FRAC;
    if (pos > limit) return 1'b0;
    pix = pos[FRAC +: awa_pkg::COORD_BITS];
    return 1'b1;
  endfunction

  // inverse map of one destination pixel
  function automatic awa_pkg::src_item_t map_to_source(input awa_pkg::dest_item_t d);
    longint                         dx, dy, sx, sy;
    logic [awa_pkg::COORD_BITS-1:0] col, row;
    logic                           hit_x, hit_y;
    awa_pkg::src_item_t             r;
    dx = d.dest_x;
    dy = d.dest_y;
    sx = longint'(mat_xx) * dx + longint'(mat_xy) * dy + longint'(mat_xt);
    sy = longint'(mat_yx) * dx + longint'(mat_yy) * dy + longint'(mat_yt);
    hit_x = axis_hit(sx, img_width, col);
    hit_y = axis_hit(sy, img_height, row);
    r = '0;
    if (hit_x && hit_y) begin
      r.src_col    = col;
      r.src_row    = row;
      r.inside_res = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    awa_pkg::src_item_t want;
    if (rst) begin
      mat_xx     = 32'sd65536;
      mat_xy     = 0;
      mat_xt     = 0;
      mat_yx     = 0;
      mat_yy     = 32'sd65536;
      mat_yt     = 0;
      img_width  = 13'd640;
      img_height = 13'd480;
      predicted_src.delete();
    end else begin
      // register writes
      if (wr_en) begin
        case (awa_pkg::reg_idx_t'(wr_index))
          awa_pkg::REG_COEF_XX:       mat_xx = wr_data;
          awa_pkg::REG_COEF_XY:       mat_xy = wr_data;
          awa_pkg::REG_COEF_XT:       mat_xt = wr_data;
          awa_pkg::REG_COEF_YX:       mat_yx = wr_data;
          awa_pkg::REG_COEF_YY:       mat_yy = wr_data;
          awa_pkg::REG_COEF_YT:       mat_yt = wr_data;
          awa_pkg::REG_SOURCE_WIDTH:  img_width  = wr_data[awa_pkg::DIM_BITS-1:0];
          awa_pkg::REG_SOURCE_HEIGHT: img_height = wr_data[awa_pkg::DIM_BITS-1:0];
          default: ;
        endcase
      end
      // compare returned item with oldest prediction
      if (src_valid && !src_stall) begin
        if (predicted_src.size() == 0) begin
          report_mismatch($sformatf("item with none predicted: col %0d row %0d inside %0b",
                                    src.src_col, src.src_row, src.inside_res));
        end else begin
          want = predicted_src.pop_front();
          if (src.src_col !== want.src_col)
            report_mismatch($sformatf("src_col expected %0d got %0d",
                                      want.src_col, src.src_col));
          if (src.src_row !== want.src_row)
            report_mismatch($sformatf("src_row expected %0d got %0d",
                                      want.src_row, src.src_row));
          if (src.inside_res !== want.inside_res)
            report_mismatch($sformatf("inside_res expected %0b got %0b",
                                      want.inside_res, src.inside_res));
        end
      end
      // predict accepted destination pixel
      if (dest_valid && !dest_stall)
        predicted_src.push_back(map_to_source(dest));
    end
    outstanding <= predicted_src.size();
  end

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives destination pixels and matrix settings into the warp address core:
// directed corner cases first, then random warps with random pixel streams,
// with random idle cycles on both channels. The checker beside the core
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 200;

  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                dest_valid = 1'b0;
  awa_pkg::dest_item_t dest       = '0;
  logic                src_stall  = 1'b0;
  logic                wr_en      = 1'b0;
  logic [2:0]          wr_index   = '0;
  logic [31:0]         wr_data    = '0;
  logic                dest_stall;
  logic                src_valid;
  awa_pkg::src_item_t  src;
  int                  mismatches;
  int                  outstanding;
  int                  quiet_cycles = 0;
  bit                  calm = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  affine_inverse_warp_address_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .dest_valid (dest_valid),
    .dest_stall (dest_stall),
    .dest       (dest),
    .src_valid  (src_valid),
    .src_stall  (src_stall),
    .src        (src),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data)
  );

  affine_inverse_warp_address_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .dest_valid  (dest_valid),
    .dest_stall  (dest_stall),
    .dest        (dest),
    .src_valid   (src_valid),
    .src_stall   (src_stall),
    .src         (src),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // random output stalls, none while calm
  always @(posedge clk) begin
    src_stall <= !rst && !calm && ($urandom_range(99) < 12);
  end

  // watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if ((dest_valid && !dest_stall) || (src_valid && !src_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one destination pixel, with random idle cycles ahead of it
  task automatic send_pixel(input logic [awa_pkg::COORD_BITS-1:0] x,
                            input logic [awa_pkg::COORD_BITS-1:0] y);
    if (!calm) begin
      while ($urandom_range(99) < 12) begin
        dest_valid <= 1'b0;
        @(posedge clk);
      end
    end
    dest_valid <= 1'b1;
    dest       <= '{dest_x: x, dest_y: y};
    @(posedge clk);
    while (dest_stall) @(posedge clk);
  endtask

  // leaves wr_en high; the caller lowers it after the last write
  task automatic write_reg(input awa_pkg::reg_idx_t idx, input logic [31:0] value);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= value;
    @(posedge clk);
  endtask

  // drain the core, then program the whole register set
  task automatic load_matrix(input logic [31:0] xx, xy, xt, yx, yy, yt,
                             input logic [awa_pkg::DIM_BITS-1:0] w, h);
    dest_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    write_reg(awa_pkg::REG_COEF_XX, xx);
    write_reg(awa_pkg::REG_COEF_XY, xy);
    write_reg(awa_pkg::REG_COEF_XT, xt);
    write_reg(awa_pkg::REG_COEF_YX, yx);
    write_reg(awa_pkg::REG_COEF_YY, yy);
    write_reg(awa_pkg::REG_COEF_YT, yt);
    write_reg(awa_pkg::REG_SOURCE_WIDTH, {{(32-awa_pkg::DIM_BITS){1'b0}}, w});
    write_reg(awa_pkg::REG_SOURCE_HEIGHT, {{(32-awa_pkg::DIM_BITS){1'b0}}, h});
    wr_en <= 1'b0;
  endtask

  // Q15.16 gain within -2.0 .. 2.0
  function automatic logic [31:0] random_gain();
    return 32'($urandom_range(0, 262144)) - 32'd131072;
  endfunction

  // Q15.16 offset within -4096.0 .. 4096.0
  function automatic logic [31:0] random_offset();
    return 32'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000;
  endfunction

  function automatic logic [awa_pkg::DIM_BITS-1:0] random_dim();
    case ($urandom_range(15))
      0:       return '0;
      1:       return awa_pkg::DIM_BITS'($urandom_range(4097, 8191));
      2:       return awa_pkg::DIM_MAX;
      default: return awa_pkg::DIM_BITS'($urandom_range(1, 4096));
    endcase
  endfunction

  initial begin
    logic [awa_pkg::COORD_BITS-1:0] row_x, row_y;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // identity after reset: corners and edges of 640x480
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd639, 12'd479);
    send_pixel(12'd640, 12'd0);
    send_pixel(12'd0, 12'd480);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd1, 12'd2);

    // half-pixel shifts: fraction past the last column, just below row zero
    load_matrix(32'h0001_0000, 32'h0, 32'h0000_8000, 32'h0, 32'h0001_0000, 32'hFFFF_8000,
                awa_pkg::DIM_MAX, awa_pkg::DIM_MAX);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4094, 12'd1);
    send_pixel(12'd4094, 12'd0);

    // zero width and height, nothing inside
    load_matrix(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 13'd0, 13'd0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd5, 12'd5);

    // oversize dimensions act as the full coordinate range
    load_matrix(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 13'd8191, 13'd4097);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd0);

    // most negative coefficients
    load_matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, awa_pkg::DIM_MAX, awa_pkg::DIM_MAX);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);

    // most positive coefficients
    load_matrix(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, awa_pkg::DIM_MAX, awa_pkg::DIM_MAX);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);

    // every pixel maps to the far source corner
    load_matrix(32'h0, 32'h0, 32'h0FFF_0000, 32'h0, 32'h0, 32'h0FFF_0000,
                awa_pkg::DIM_MAX, awa_pkg::DIM_MAX);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd0);

    // transpose into a two-row source
    load_matrix(32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h0,
                awa_pkg::DIM_MAX, 13'd2);
    send_pixel(12'd3, 12'd1);
    send_pixel(12'd1, 12'd3);

    // random warps, each with raster runs and scattered pixels
    for (int p = 0; p < PHASES; p++) begin
      if ($urandom_range(3) == 0)
        load_matrix($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    awa_pkg::DIM_BITS'($urandom_range(0, 8191)),
                    awa_pkg::DIM_BITS'($urandom_range(0, 8191)));
      else
        load_matrix(random_gain(), random_gain(), random_offset(),
                    random_gain(), random_gain(), random_offset(),
                    random_dim(), random_dim());
      calm = (p == PHASES / 2);
      row_x = '0;
      row_y = '0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 < 25) begin
          if (n % 50 == 0) begin
            row_x = awa_pkg::COORD_BITS'($urandom);
            row_y = awa_pkg::COORD_BITS'($urandom);
          end
          send_pixel(row_x, row_y);
          row_x = row_x + 1'b1;
        end else begin
          send_pixel(awa_pkg::COORD_BITS'($urandom), awa_pkg::COORD_BITS'($urandom));
        end
      end
      calm = 1'b0;
    end

    // drain and verdict
    dest_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
